[hw/rtl/tmo_pkg.sv]
// shared types and constants of the timed marker overlay
package tmo_pkg;

	localparam int CENTRE_W   = 13;
	localparam int CFG_DIM_W  = 13;
	localparam int DIM_CMP_W  = 14;
	localparam int SLOT_W     = 4;
	localparam int PCT_W      = 7;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;

	// floor(n/100) = (n * DIV100_RECIP) >> DIV100_SHIFT for every n below 2**20
	localparam int DIV100_SHIFT = 26;
	localparam int RECIP_W      = 20;
	localparam logic [RECIP_W-1:0] DIV100_RECIP = 20'd671089;
	localparam int QMUL_W       = DIV100_SHIFT + CENTRE_W + 1;

	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

	localparam logic OP_POINT = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 13'd480;

	localparam logic [7:0] MARK_RED   = 8'd255;
	localparam logic [7:0] MARK_GREEN = 8'd0;
	localparam logic [7:0] MARK_BLUE  = 8'd255;

	typedef struct packed {
		logic             opcode;
		logic [SLOT_W-1:0] slot;
		logic [PCT_W-1:0] x_percent;
		logic [PCT_W-1:0] y_percent;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [7:0]       alpha;
		logic             end_of_frame;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic       out_end_of_frame;
		logic       marked;
	} out_word_t;

	typedef struct packed {
		logic                set_en;
		logic [SLOT_W-1:0]   slot;
		logic [CENTRE_W-1:0] col;
		logic [CENTRE_W-1:0] row;
		logic                tick;
	} mk_ctrl_t;

endpackage

[hw/rtl/tmo_pos_counter.sv]
// raster column and row counters of the incoming pixel stream
module tmo_pos_counter #(
	parameter int CNT_W = 12,
	parameter int DIM_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             eof,
	input  logic [DIM_W-1:0] w,
	input  logic [DIM_W-1:0] h,
	output logic [CNT_W-1:0] col,
	output logic [CNT_W-1:0] row
);

	localparam int CMP_W = DIM_W + 1;

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [CMP_W-1:0] col_inc;
	logic [CMP_W-1:0] row_inc;

	assign col_inc = CMP_W'(col_q) + CMP_W'(1);
	assign row_inc = CMP_W'(row_q) + CMP_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (eof) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc >= CMP_W'(w)) begin
				// line end
				col_q <= '0;
				if (row_inc >= CMP_W'(h)) begin
					row_q <= '0;
				end else begin
					row_q <= row_inc[CNT_W-1:0];
				end
			end else begin
				col_q <= col_inc[CNT_W-1:0];
			end
		end
	end

	assign col = col_q;
	assign row = row_q;

endmodule

[hw/rtl/tmo_marker_table.sv]
// marker slots: centres, remaining life and the per-pixel cover test
module tmo_marker_table #(
	parameter int NUM_MARKERS   = 10,
	parameter int MARKER_RADIUS = 5,
	parameter int MARKER_LIFE   = 30,
	parameter int CNT_W         = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tmo_pkg::mk_ctrl_t   ctrl,
	input  logic [CNT_W-1:0]    col,
	input  logic [CNT_W-1:0]    row,
	output logic                any_hit
);

	localparam int LIFE_W = $clog2(MARKER_LIFE + 1);
	localparam int CW     = tmo_pkg::CENTRE_W;

	logic [CW-1:0]     centre_col_q [NUM_MARKERS];
	logic [CW-1:0]     centre_row_q [NUM_MARKERS];
	logic [LIFE_W-1:0] life_q       [NUM_MARKERS];
	logic [NUM_MARKERS-1:0] slot_hit;

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_MARKERS; k++) begin
			if (ctrl.set_en && ctrl.slot == tmo_pkg::SLOT_W'(k)) begin
				centre_col_q[k] <= ctrl.col;
				centre_row_q[k] <= ctrl.row;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_MARKERS; k++) begin
				life_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < NUM_MARKERS; k++) begin
				if (ctrl.set_en && ctrl.slot == tmo_pkg::SLOT_W'(k)) begin
					life_q[k] <= LIFE_W'(MARKER_LIFE);
				end else if (ctrl.tick && life_q[k] != '0) begin
					life_q[k] <= life_q[k] - LIFE_W'(1);
				end
			end
		end
	end

	// one comparator pair per slot
	always_comb begin
		logic [CW-1:0] pc;
		logic [CW-1:0] pr;
		logic [CW-1:0] dc;
		logic [CW-1:0] dr;
		pc = CW'(col);
		pr = CW'(row);
		for (int k = 0; k < NUM_MARKERS; k++) begin
			dc = (pc > centre_col_q[k]) ? pc - centre_col_q[k] : centre_col_q[k] - pc;
			dr = (pr > centre_row_q[k]) ? pr - centre_row_q[k] : centre_row_q[k] - pr;
			slot_hit[k] = (life_q[k] != '0) && (dc <= CW'(MARKER_RADIUS))
				&& (dr <= CW'(MARKER_RADIUS));
		end
	end

	assign any_hit = |slot_hit;

endmodule

[hw/rtl/timed_marker_overlay.sv]
// timed marker overlay top level: config registers, input stage and result register
// path: a pixel word waits in the input register, then is loaded into the result
//   register once that register is empty or being read
// throughput: one word per cycle, point and pixel words alike, unless a pixel word
//   waits on a stalled result; set by the one compute stage between the registers
// reset: arst_n clears markers (all dead), counters, config to enable 0, 640 x 480
module timed_marker_overlay #(
	parameter int NUM_MARKERS   = 10,
	parameter int MAX_DIM       = 4096,
	parameter int MARKER_RADIUS = 5,
	parameter int MARKER_LIFE   = 30
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input word channel
	input  logic                         item_valid,
	output logic                         item_ready,
	input  tmo_pkg::in_word_t            item,
	// result word channel
	output logic                         result_valid,
	input  logic                         result_ready,
	output tmo_pkg::out_word_t           result,
	// config port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tmo_pkg::ADDR_W-1:0]   paddr,
	input  logic [tmo_pkg::DATA_W-1:0]   pwdata,
	output logic [tmo_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int CNT_W  = $clog2(MAX_DIM);
	localparam int PROD_W = DIM_W + tmo_pkg::PCT_W;
	localparam int CW     = tmo_pkg::CENTRE_W;
	localparam int QW     = tmo_pkg::QMUL_W;
	localparam int SH     = tmo_pkg::DIV100_SHIFT;

	// ---------------------------------------------------------------
	// config registers
	// ---------------------------------------------------------------
	logic                          enable_q;
	logic [tmo_pkg::CFG_DIM_W-1:0] width_q;
	logic [tmo_pkg::CFG_DIM_W-1:0] height_q;
	logic                          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			width_q  <= tmo_pkg::WIDTH_RESET;
			height_q <= tmo_pkg::HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				tmo_pkg::REG_ENABLE: enable_q <= pwdata[0];
				tmo_pkg::REG_WIDTH:  width_q  <= pwdata[tmo_pkg::CFG_DIM_W-1:0];
				tmo_pkg::REG_HEIGHT: height_q <= pwdata[tmo_pkg::CFG_DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			tmo_pkg::REG_ENABLE: prdata = tmo_pkg::DATA_W'(enable_q);
			tmo_pkg::REG_WIDTH:  prdata = tmo_pkg::DATA_W'(width_q);
			tmo_pkg::REG_HEIGHT: prdata = tmo_pkg::DATA_W'(height_q);
			default:             prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// frame size in use: zero reads as one, large sizes saturate
	// ---------------------------------------------------------------
	logic [DIM_W-1:0] w_lim;
	logic [DIM_W-1:0] h_lim;

	always_comb begin
		if (width_q == '0) begin
			w_lim = DIM_W'(1);
		end else if (tmo_pkg::DIM_CMP_W'(width_q) > tmo_pkg::DIM_CMP_W'(MAX_DIM)) begin
			w_lim = DIM_W'(MAX_DIM);
		end else begin
			w_lim = DIM_W'(width_q);
		end
		if (height_q == '0) begin
			h_lim = DIM_W'(1);
		end else if (tmo_pkg::DIM_CMP_W'(height_q) > tmo_pkg::DIM_CMP_W'(MAX_DIM)) begin
			h_lim = DIM_W'(MAX_DIM);
		end else begin
			h_lim = DIM_W'(height_q);
		end
	end

	// ---------------------------------------------------------------
	// input stage: clamp percent and take size * percent on the way in,
	// the divide by 100 happens after the register
	// ---------------------------------------------------------------
	logic [tmo_pkg::PCT_W-1:0] x_pct;
	logic [tmo_pkg::PCT_W-1:0] y_pct;

	assign x_pct = (item.x_percent > tmo_pkg::PCT_MAX) ? tmo_pkg::PCT_MAX : item.x_percent;
	assign y_pct = (item.y_percent > tmo_pkg::PCT_MAX) ? tmo_pkg::PCT_MAX : item.y_percent;

	logic                      valid_s1;
	tmo_pkg::in_word_t         word_s1;
	logic [PROD_W-1:0]         x_prod_s1;
	logic [PROD_W-1:0]         y_prod_s1;
	logic                      proceed;
	logic                      take;

	// a point word never needs the result register, a pixel word needs it free
	assign proceed = valid_s1
		&& (word_s1.opcode == tmo_pkg::OP_POINT || !result_valid || result_ready);
	assign item_ready = !valid_s1 || proceed;
	assign take = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (proceed) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s1   <= item;
			x_prod_s1 <= PROD_W'(w_lim) * PROD_W'(x_pct);
			y_prod_s1 <= PROD_W'(h_lim) * PROD_W'(y_pct);
		end
	end

	// ---------------------------------------------------------------
	// compute stage: divide by 100 through the reciprocal, cover test
	// ---------------------------------------------------------------
	logic [QW-1:0] x_q;
	logic [QW-1:0] y_q;

	assign x_q = QW'(x_prod_s1) * QW'(tmo_pkg::DIV100_RECIP);
	assign y_q = QW'(y_prod_s1) * QW'(tmo_pkg::DIV100_RECIP);

	tmo_pkg::mk_ctrl_t mk_ctrl;
	logic              is_pixel;
	logic [CNT_W-1:0]  col;
	logic [CNT_W-1:0]  row;
	logic              any_hit;
	logic              hit;

	assign is_pixel = word_s1.opcode == tmo_pkg::OP_PIXEL;

	always_comb begin
		mk_ctrl.set_en = proceed && !is_pixel && enable_q
			&& ({1'b0, word_s1.slot} < (tmo_pkg::SLOT_W + 1)'(NUM_MARKERS));
		mk_ctrl.slot   = word_s1.slot;
		mk_ctrl.col    = x_q[SH +: CW];
		mk_ctrl.row    = y_q[SH +: CW];
		// life runs out one frame per end of frame, only while enabled
		mk_ctrl.tick   = proceed && is_pixel && word_s1.end_of_frame && enable_q;
	end

	tmo_pos_counter #(
		.CNT_W (CNT_W),
		.DIM_W (DIM_W)
	) u_pos (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (proceed && is_pixel),
		.eof     (word_s1.end_of_frame),
		.w       (w_lim),
		.h       (h_lim),
		.col     (col),
		.row     (row)
	);

	tmo_marker_table #(
		.NUM_MARKERS   (NUM_MARKERS),
		.MARKER_RADIUS (MARKER_RADIUS),
		.MARKER_LIFE   (MARKER_LIFE),
		.CNT_W         (CNT_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mk_ctrl),
		.col     (col),
		.row     (row),
		.any_hit (any_hit)
	);

	assign hit = enable_q && any_hit;

	// ---------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------
	logic              out_valid_q;
	tmo_pkg::out_word_t out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proceed && is_pixel) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && is_pixel) begin
			out_word_q.out_red          <= hit ? tmo_pkg::MARK_RED : word_s1.red;
			out_word_q.out_green        <= hit ? tmo_pkg::MARK_GREEN : word_s1.green;
			out_word_q.out_blue         <= hit ? tmo_pkg::MARK_BLUE : word_s1.blue;
			out_word_q.out_alpha        <= word_s1.alpha;
			out_word_q.out_end_of_frame <= word_s1.end_of_frame;
			out_word_q.marked           <= hit;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_word_q;

endmodule

[hw/rtl/tmo_checker.sv]
// port-level checks of the timed marker overlay and their bind
module tmo_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input logic               result_valid,
	input logic               result_ready,
	input tmo_pkg::out_word_t result
);

	// stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// a marked pixel is painted in the marker color
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.marked |-> result.out_red == tmo_pkg::MARK_RED
			&& result.out_green == tmo_pkg::MARK_GREEN
			&& result.out_blue == tmo_pkg::MARK_BLUE)
		else $error("marked pixel not in marker color");

	// input only stalls behind a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid && !result_ready)
		else $error("input stalled without output back-pressure");

	// a fresh result comes from an accepted word, through the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && item_ready, 2))
		else $error("result word without accepted input word");

endmodule

bind timed_marker_overlay tmo_checker u_tmo_checker (.*);
